>>> rtl/scbd_pkg.sv
`default_nettype none

package scbd_pkg;

	// Single-byte commands
	localparam logic [7:0] BYTE_STOP_CLR = 8'h4D;
	localparam logic [7:0] BYTE_LAMP     = 8'h58;
	localparam logic [7:0] BYTE_DIR_LO   = 8'h41;
	localparam logic [7:0] BYTE_DIR_HI   = 8'h4C;
	localparam logic [7:0] BYTE_DIR_MAX  = 8'd12;

	// One-shot code bytes and the codes they latch
	localparam logic [7:0] BYTE_CODE_12 = 8'h12;
	localparam logic [7:0] BYTE_CODE_22 = 8'h22;
	localparam logic [7:0] BYTE_CODE_21 = 8'h21;
	localparam logic [7:0] BYTE_CODE_11 = 8'h11;
	localparam logic [4:0] CODE_12      = 5'd12;
	localparam logic [4:0] CODE_22      = 5'd22;
	localparam logic [4:0] CODE_21      = 5'd21;
	localparam logic [4:0] CODE_11      = 5'd11;

	// Frame bytes
	localparam logic [7:0] BYTE_OPEN    = 8'h7B;
	localparam logic [7:0] BYTE_CLOSE   = 8'h7D;
	localparam logic [7:0] BYTE_REPORT  = 8'h50;
	localparam logic [7:0] BYTE_SAVE    = 8'h57;
	localparam logic [7:0] ID_NONE      = 8'h23;
	localparam logic [7:0] ID_LO        = 8'h30;
	localparam logic [7:0] ID_HI        = 8'h34;
	localparam logic [7:0] DIGIT_ZERO   = 8'd48;

	// Frame positions
	localparam int unsigned POS_ID    = 1;
	localparam int unsigned POS_FOURTH = 3;

	// Stream widths
	localparam int unsigned IN_W  = 8;
	localparam int unsigned RES_W = 50;
	localparam int unsigned OUT_W = 56;

	// Saturation bounds
	localparam logic signed [35:0] ACC_MAX = 36'sd2147483647;
	localparam logic signed [35:0] ACC_MIN = -36'sd2147483648;

	typedef struct packed {
		logic               save_request;
		logic               report_request;
		logic signed [31:0] param_value;
		logic [2:0]         param_select;
		logic               param_write;
		logic [4:0]         latched_code;
		logic               lamp_state;
		logic               stop_clear;
		logic [3:0]         direction;
		logic               direction_valid;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/serial_command_byte_decoder.sv
`default_nettype none

// Serial command byte decoder. Each beat on s_axis carries one received serial byte; each
// accepted byte yields exactly one result beat on m_axis. The byte decodes single-byte
// commands (direction, stop clear, lamp toggle, one-shot codes) and feeds a '{' ... '}'
// framed parser that keeps the parameter id, frame byte 3 and a saturating decimal value,
// and on '}' raises a report, save or parameter-write pulse. The block takes one byte per
// cycle while m_axis is not stalled; each accepted byte is registered in the input register,
// decoded from it and registered in the result register, which drives the result beat. The
// per-byte rate is set by the value update, a 36-bit times-ten add with saturation.
// cfg_we writes direction_update_enable (reset 1) and must only be used while no byte is
// in flight.
module serial_command_byte_decoder #(
	parameter int MAX_FRAME = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_wdata,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// [7:0] rx_byte
	input  wire logic [scbd_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// [0] direction_valid, [4:1] direction, [5] stop_clear, [6] lamp_state,
	// [11:7] latched_code, [12] param_write, [15:13] param_select,
	// [47:16] param_value, [48] report_request, [49] save_request, [55:50] zero
	output logic [scbd_pkg::OUT_W-1:0]       m_axis_tdata
);

	import scbd_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME + 1);

	// Configuration
	logic dir_en_q;

	// Input register
	logic       v_s1;
	logic [7:0] byte_s1;

	// Decoder state
	logic              in_frame_q;
	logic [CNT_W-1:0]  frame_cnt_q;
	logic [7:0]        id_q;
	logic [7:0]        fourth_q;
	logic signed [31:0] acc_q;
	logic [3:0]        code_done_q;
	logic [4:0]        code_q;
	logic              lamp_q;
	logic [3:0]        dir_q;

	// Result register
	logic    v_s2;
	result_t res_s2;

	// Next state
	logic              in_frame_n;
	logic [CNT_W-1:0]  frame_cnt_n;
	logic [7:0]        id_n;
	logic [7:0]        fourth_n;
	logic signed [31:0] acc_n;
	logic [3:0]        code_done_n;
	logic [4:0]        code_n;
	logic              lamp_n;
	logic [3:0]        dir_n;
	result_t           res_n;

	logic               adv;
	logic signed [35:0] acc_ext;
	logic signed [35:0] acc_sum;
	logic signed [31:0] acc_sat;

	// Handshake: the input register moves into the result register when that is free
	assign adv           = v_s1 && (!v_s2 || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;
	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {(OUT_W - RES_W)'(0), res_s2};

	// Times ten plus digit, saturated to 32 bits
	assign acc_ext = 36'(acc_q);
	assign acc_sum = (acc_ext <<< 3) + (acc_ext <<< 1)
		+ ($signed({28'd0, byte_s1}) - $signed({28'd0, DIGIT_ZERO}));
	always_comb begin
		if (acc_sum > ACC_MAX) begin
			acc_sat = 32'sh7FFF_FFFF;
		end else if (acc_sum < ACC_MIN) begin
			acc_sat = 32'sh8000_0000;
		end else begin
			acc_sat = acc_sum[31:0];
		end
	end

	// Decode one byte
	always_comb begin
		in_frame_n  = in_frame_q;
		frame_cnt_n = frame_cnt_q;
		id_n        = id_q;
		fourth_n    = fourth_q;
		acc_n       = acc_q;
		code_done_n = code_done_q;
		code_n      = code_q;
		lamp_n      = lamp_q;
		dir_n       = dir_q;
		res_n       = '0;

		res_n.stop_clear = (byte_s1 == BYTE_STOP_CLR);

		// One-shot codes, each only the first time it is seen
		if (byte_s1 == BYTE_CODE_12 && !code_done_q[0]) begin
			code_n = CODE_12;
			code_done_n[0] = 1'b1;
		end
		if (byte_s1 == BYTE_CODE_22 && !code_done_q[1]) begin
			code_n = CODE_22;
			code_done_n[1] = 1'b1;
		end
		if (byte_s1 == BYTE_CODE_21 && !code_done_q[2]) begin
			code_n = CODE_21;
			code_done_n[2] = 1'b1;
		end
		if (byte_s1 == BYTE_CODE_11 && !code_done_q[3]) begin
			code_n = CODE_11;
			code_done_n[3] = 1'b1;
		end

		if (byte_s1 == BYTE_LAMP) begin
			lamp_n = !lamp_q;
		end

		// Direction follows every byte while enabled
		if (dir_en_q) begin
			if (byte_s1 >= BYTE_DIR_LO && byte_s1 <= BYTE_DIR_HI) begin
				dir_n = 4'(byte_s1 - BYTE_DIR_LO + 8'd1);
			end else if (byte_s1 <= BYTE_DIR_MAX) begin
				dir_n = byte_s1[3:0];
			end else begin
				dir_n = 4'd0;
			end
			res_n.direction_valid = 1'b1;
		end

		// Framed layer
		if (byte_s1 == BYTE_CLOSE) begin
			if (in_frame_q) begin
				if (fourth_q == BYTE_REPORT) begin
					res_n.report_request = 1'b1;
				end else if (fourth_q == BYTE_SAVE) begin
					res_n.save_request = 1'b1;
				end else if (id_q != ID_NONE && id_q >= ID_LO && id_q <= ID_HI) begin
					res_n.param_write  = 1'b1;
					res_n.param_select = 3'(id_q - ID_LO);
					res_n.param_value  = acc_q;
				end
			end
			in_frame_n  = 1'b0;
			frame_cnt_n = '0;
			id_n        = '0;
			fourth_n    = '0;
			acc_n       = '0;
		end else begin
			if (byte_s1 == BYTE_OPEN) begin
				in_frame_n = 1'b1;
			end
			if (in_frame_n && frame_cnt_q < CNT_W'(MAX_FRAME)) begin
				if (frame_cnt_q == CNT_W'(POS_ID)) begin
					id_n = byte_s1;
				end
				if (frame_cnt_q == CNT_W'(POS_FOURTH)) begin
					fourth_n = byte_s1;
				end
				if (frame_cnt_q >= CNT_W'(POS_FOURTH)) begin
					acc_n = acc_sat;
				end
				frame_cnt_n = frame_cnt_q + CNT_W'(1);
			end
		end

		res_n.direction    = dir_n;
		res_n.lamp_state   = lamp_n;
		res_n.latched_code = code_n;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_en_q <= 1'b1;
		end else if (cfg_we) begin
			dir_en_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Advance decoder state with each byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			frame_cnt_q <= '0;
			id_q        <= '0;
			fourth_q    <= '0;
			acc_q       <= '0;
			code_done_q <= '0;
			code_q      <= '0;
			lamp_q      <= 1'b0;
			dir_q       <= '0;
		end else if (adv) begin
			in_frame_q  <= in_frame_n;
			frame_cnt_q <= frame_cnt_n;
			id_q        <= id_n;
			fourth_q    <= fourth_n;
			acc_q       <= acc_n;
			code_done_q <= code_done_n;
			code_q      <= code_n;
			lamp_q      <= lamp_n;
			dir_q       <= dir_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (!v_s2 || m_axis_tready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_n;
		end
	end

`ifndef SYNTHESIS
	a_one_frame_action: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $onehot0({res_s2.param_write, res_s2.report_request, res_s2.save_request}))
		else $error("more than one frame action in one result");

	a_idle_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (frame_cnt_q == '0 && acc_q == '0 && id_q == '0 && fourth_q == '0))
		else $error("frame state left over outside a frame");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frame_cnt_q <= CNT_W'(MAX_FRAME))
		else $error("frame count past bound");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !m_axis_tready |=> v_s2 && $stable(res_s2))
		else $error("result dropped while stalled");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(byte_s1))
		else $error("input byte lost while result stage busy");

	a_select_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && res_s2.param_write |-> res_s2.param_select <= 3'd4)
		else $error("parameter select out of range");
`endif

endmodule

`default_nettype wire
